@@ hw/rtl/bmh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared constants, tables and types for the byte mixing hash block.
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned HALF_W = VAL_W / 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned SHAMT_W = 5;

  localparam logic [VAL_W-1:0] RESET_VALUE = 64'h0000_0000_0005_4e55;

  // Finaliser multiplies, in order: two mix rounds, then K0 and (1 + Ki)
  localparam int unsigned NUM_MUL = 6;
  localparam int unsigned STEP_W  = $clog2(NUM_MUL);
  localparam logic [HALF_W-1:0] MUL_CONST [NUM_MUL] = '{
    32'h045d_9f3b,
    32'h045d_9f3b,
    32'hd76a_a478,
    32'he8c7_b757,
    32'h2420_70dc,
    32'hc1bd_ceef
  };

  // Queue between absorb and finalise
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_SHR,
    PRE_SHL
  } pre_op_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_MLO,
    F_MHI,
    F_ADD,
    F_DONE
  } fin_state_t;

  function automatic logic [SHAMT_W-1:0] shift_amt(input logic [POS_W-1:0] pos);
    logic [SHAMT_W-1:0] r;
    unique case (pos)
      3'd0: r = 5'd3;
      3'd1: r = 5'd5;
      3'd2: r = 5'd7;
      3'd3: r = 5'd11;
      3'd4: r = 5'd13;
      3'd5: r = 5'd17;
      3'd6: r = 5'd19;
      3'd7: r = 5'd23;
      default: r = 5'd3;
    endcase
    return r;
  endfunction

  function automatic pre_op_t pre_op(input logic [STEP_W-1:0] step);
    pre_op_t r;
    unique case (step)
      3'd0:    r = PRE_SHR;
      3'd1:    r = PRE_SHL;
      3'd2:    r = PRE_SHR;
      default: r = PRE_NONE;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/bmh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_front
// Absorbs one byte a cycle while accept is high into the running value; on
// the last word hands the absorbed value to the finaliser queue and restarts.
// ----------------------------------------------------------------------------
module bmh_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [bmh_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        has_byte,
  input  logic                        last,
  output logic                        q_push,
  output logic [bmh_pkg::VAL_W-1:0]   q_data
);
  import bmh_pkg::*;

  logic [VAL_W-1:0]   value;
  logic [VAL_W-1:0]   value_next;
  logic [POS_W-1:0]   pos;
  logic [SHAMT_W-1:0] sh_a;
  logic [SHAMT_W-1:0] sh_b;
  logic [VAL_W-1:0]   byte_ext;
  logic [VAL_W-1:0]   mixed;

  always_comb begin
    sh_a     = shift_amt(pos);
    sh_b     = shift_amt(pos + POS_W'(1));
    byte_ext = {{(VAL_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};
    mixed    = value ^ ((value << sh_a) + byte_ext + (value >> sh_b));
    value_next = has_byte ? mixed : value;
  end

  assign q_push = accept & last;
  assign q_data = value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= RESET_VALUE;
      pos   <= '0;
    end else if (accept) begin
      if (last) begin
        value <= RESET_VALUE;
        pos   <= '0;
      end else if (has_byte) begin
        value <= mixed;
        pos   <= pos + POS_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/bmh_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_fifo
// Short queue of absorbed values waiting for the finaliser.
// ----------------------------------------------------------------------------
module bmh_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [bmh_pkg::VAL_W-1:0]  wr_data,
  input  logic                       rd_en,
  output logic [bmh_pkg::VAL_W-1:0]  rd_data,
  output logic                       q_full,
  output logic                       q_empty
);
  import bmh_pkg::*;

  logic [VAL_W-1:0]  slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/bmh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_back
// Finaliser: xor-shift rounds and six 64x32 multiplies on one shared 32x32
// multiplier, then a result register that drives the output queue side.
// ----------------------------------------------------------------------------
module bmh_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  logic [bmh_pkg::VAL_W-1:0]  q_data,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [bmh_pkg::VAL_W-1:0]  digest
);
  import bmh_pkg::*;

  fin_state_t        state;
  fin_state_t        state_next;
  logic [STEP_W-1:0] step;
  logic [VAL_W-1:0]  value;
  logic [VAL_W-1:0]  prod_lo;
  logic [VAL_W-1:0]  prod_hi;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_c;
  logic [VAL_W-1:0]  mul_p;
  logic              out_valid;
  logic              out_load;
  logic              last_step;

  assign last_step = (step == STEP_W'(NUM_MUL-1));
  assign mul_c     = MUL_CONST[step];
  assign mul_a     = (state == F_MLO) ? value[HALF_W-1:0] : value[VAL_W-1:HALF_W];
  assign mul_p     = VAL_W'(mul_a) * VAL_W'(mul_c);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (!q_empty) state_next = F_PREP;
      F_PREP: state_next = F_MLO;
      F_MLO:  state_next = F_MHI;
      F_MHI:  state_next = F_ADD;
      F_ADD:  state_next = last_step ? F_DONE : F_PREP;
      F_DONE: if (!out_valid || pop) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == F_IDLE) && !q_empty;
    out_load = (state == F_DONE) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE) begin
        step <= '0;
      end else if (state == F_ADD && !last_step) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: value <= q_data;
      F_PREP: begin
        unique case (pre_op(step))
          PRE_SHR: value <= value ^ (value >> BYTE_W);
          PRE_SHL: value <= value ^ (value << BYTE_W);
          default: value <= value;
        endcase
      end
      F_MLO: prod_lo <= mul_p;
      F_MHI: prod_hi <= mul_p;
      // low product plus high product moved up a half word, mod 2^64
      F_ADD: value <= prod_lo + {prod_hi[HALF_W-1:0], {HALF_W{1'b0}}};
      default: value <= value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest <= value;
    end
  end

  assign empty = ~out_valid;

endmodule

@@ hw/rtl/byte_mixing_hash64_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_mixing_hash64_top
// 64-bit hash of a byte stream, one byte per word, digest on the last word.
// ----------------------------------------------------------------------------
// Bytes are absorbed at one word per cycle while full is low; full is high
// only while the queue between absorb and finaliser holds two finished
// messages. Each message is loaded from the queue into the finaliser, goes
// through six 64x32 multiplies (prep, low, high and add steps each) on one
// shared 32x32 multiplier, and is then handed over to the result register.
// A word with has_byte low and last high finalises without absorbing, which
// right after reset yields the digest of the empty message.
module byte_mixing_hash64_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [bmh_pkg::BYTE_W-1:0] data_byte,
  input  logic                       has_byte,
  input  logic                       last,
  output logic                       empty,
  input  logic                       pop,
  output logic [bmh_pkg::VAL_W-1:0]  digest
);
  import bmh_pkg::*;

  logic             accept;
  logic             q_push;
  logic [VAL_W-1:0] q_wdata;
  logic [VAL_W-1:0] q_rdata;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  assign full   = q_full;
  assign accept = push & ~q_full;

  bmh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  bmh_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  bmh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .digest  (digest)
  );

endmodule
